// File: rtl/ispm_pkg.sv
// shared types and constants of the interpolating sample player mixer
// no dependencies; imported by every other file of the block except ispm_ram
package ispm_pkg;

   // storage and number format
   localparam int SAMPLE_DEPTH = 32768;
   localparam int FRAC_BITS    = 16;
   localparam int ADDR_W       = $clog2(SAMPLE_DEPTH);
   localparam int SAMPLE_W     = 16;
   localparam int LOAD_ADDR_W  = 15;

   // configuration registers
   localparam int BASE_STEP_W  = 18;
   localparam int CLIP_W       = 16;
   localparam int CSR_INDEX_W  = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_STEP   = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLIP_LENGTH = 1'b1;
   localparam logic [BASE_STEP_W-1:0] BASE_STEP_RESET = 18'd65536;
   localparam logic [CLIP_W-1:0]      CLIP_RESET      = 16'd32768;

   // voice state widths
   localparam int POS_W      = 32;
   localparam int STEP_W     = 22;
   localparam int RATE_W     = 16;
   localparam int GAIN_W     = 16;
   localparam int RATE_SHIFT = 12;
   localparam int IDX_W      = POS_W - FRAC_BITS;
   localparam int CMP_W      = POS_W + 1;

   // mix arithmetic widths
   localparam int N_W   = SAMPLE_W + FRAC_BITS;
   localparam int NX_W  = N_W + 2;
   localparam int P_W   = N_W + GAIN_W + 1;
   localparam int SHIFT = FRAC_BITS + 15;
   localparam int S_W   = P_W - SHIFT;

   // command codes
   localparam logic [1:0] CMD_MIX  = 2'd0;
   localparam logic [1:0] CMD_PLAY = 2'd1;
   localparam logic [1:0] CMD_STOP = 2'd2;
   localparam logic [1:0] CMD_LOAD = 2'd3;

   // controller to datapath commands
   typedef struct packed {
      logic take;      // input transaction accepted this cycle
      logic pass;      // frame leaves unmixed
      logic rd_a;      // read sample at index
      logic rd_b;      // capture first sample, read sample at index plus one
      logic mul1;      // interpolate the two samples
      logic mul2;      // scale by gain
      logic mix;       // truncate, add to channels, advance position
      logic out_load;  // move result into the output register
   } ctl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic active;
      logic at_end;
   } dp_status_type;

endpackage

// File: rtl/interpolating_sample_player_mixer.sv
// top level of the interpolating sample player mixer
// depends on ispm_pkg, ispm_ctrl, ispm_dp (and ispm_ram through ispm_dp)
// usage:
// - req_ channel takes commands: mix frame, play, stop, load sample. a transaction
//   is taken at a clock edge with req_valid high and req_stall low.
// - only mix frame commands give a result, on the rsp_ channel, taken when
//   rsp_valid is high and rsp_stall low.
// - csr_ channel writes base_step (index 0) and clip_length (index 1); csr_ready
//   is always high. write only while the block is idle.
// - play, stop and load complete when accepted and leave the block idle.
// - a frame with no voice playing, or the frame that ends the voice, passes
//   through EVAL and OUT before rsp_valid rises; an interpolated frame goes
//   through two sequential reads of the single-read sample memory (EVAL, RD_B),
//   then the interpolation and gain multiplies, the truncate/add stage and OUT.
// - one transaction is processed at a time; the next is accepted the cycle after
//   a frame's result enters the output register.
// - while the receiver stalls, the result holds in the output register and the
//   next frame waits in its final step until the register is free.
// - synchronous reset clears the voice and the registers to their defaults;
//   sample memory contents are undefined until loaded. no clearing pass.
module interpolating_sample_player_mixer import ispm_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_command,
   input  logic signed [15:0]          req_left_in,
   input  logic signed [15:0]          req_right_in,
   input  logic [RATE_W-1:0]           req_play_rate,
   input  logic [GAIN_W-1:0]           req_play_volume,
   input  logic [LOAD_ADDR_W-1:0]      req_load_address,
   input  logic signed [SAMPLE_W-1:0]  req_load_value,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [15:0]          rsp_left_out,
   output logic signed [15:0]          rsp_right_out,
   output logic                        rsp_voice_active,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [CSR_INDEX_W-1:0]      csr_index,
   input  logic [BASE_STEP_W-1:0]      csr_wdata
);

   ctl_cmd_type   ctl;
   dp_status_type status;

   assign csr_ready = 1'b1;

   // sequencer
   ispm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_command(req_command),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .status     (status),
      .ctl        (ctl)
   );

   // datapath
   ispm_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .ctl             (ctl),
      .status          (status),
      .csr_write       (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_command     (req_command),
      .req_left_in     (req_left_in),
      .req_right_in    (req_right_in),
      .req_play_rate   (req_play_rate),
      .req_play_volume (req_play_volume),
      .req_load_address(req_load_address),
      .req_load_value  (req_load_value),
      .rsp_left_out    (rsp_left_out),
      .rsp_right_out   (rsp_right_out),
      .rsp_voice_active(rsp_voice_active)
   );

endmodule

// File: rtl/ispm_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module ispm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32768
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/ispm_dp.sv
// datapath: configuration registers, voice state, sample memory and mix arithmetic
// depends on ispm_pkg and ispm_ram
module ispm_dp import ispm_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  ctl_cmd_type                 ctl,
   output dp_status_type               status,
   input  logic                        csr_write,
   input  logic [CSR_INDEX_W-1:0]      csr_index,
   input  logic [BASE_STEP_W-1:0]      csr_wdata,
   input  logic [1:0]                  req_command,
   input  logic signed [15:0]          req_left_in,
   input  logic signed [15:0]          req_right_in,
   input  logic [RATE_W-1:0]           req_play_rate,
   input  logic [GAIN_W-1:0]           req_play_volume,
   input  logic [LOAD_ADDR_W-1:0]      req_load_address,
   input  logic signed [SAMPLE_W-1:0]  req_load_value,
   output logic signed [15:0]          rsp_left_out,
   output logic signed [15:0]          rsp_right_out,
   output logic                        rsp_voice_active
);

   localparam logic [P_W-1:0] ROUND_BIAS = {{(P_W-SHIFT){1'b0}}, {SHIFT{1'b1}}};

   logic [BASE_STEP_W-1:0] base_step_ff;
   logic [CLIP_W-1:0]      clip_ff;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [STEP_W-1:0]      step_ff;
   logic [GAIN_W-1:0]      gain_ff;
   logic                   active_ff, active_in;

   logic signed [15:0]       left_ff, right_ff;
   logic signed [SAMPLE_W-1:0] a_ff;
   logic signed [N_W-1:0]    n_ff, n_in;
   logic signed [P_W-1:0]    p_ff, p_in;
   logic signed [15:0]       res_left_ff, res_right_ff, res_left_in, res_right_in;
   logic                     res_active_ff;
   logic signed [15:0]       out_left_ff, out_right_ff;
   logic                     out_active_ff;

   logic [BASE_STEP_W+RATE_W-1:0] step_prod;
   logic [IDX_W-1:0]      idx, idx_next;
   logic [CMP_W-1:0]      limit;
   logic                  ram_we, ram_re;
   logic [ADDR_W-1:0]     ram_raddr;
   logic signed [SAMPLE_W-1:0] ram_rdata;
   logic signed [SAMPLE_W:0]   diff;
   logic signed [NX_W-1:0]     a_sh, term, nx;
   logic [FRAC_BITS-1:0]       frac;
   logic [P_W-1:0]             p_adj;
   logic signed [S_W-1:0]      s_val;
   logic signed [18:0]         sum_left, sum_right;
   logic [63:0]                inc_wide;
   logic [CMP_W-1:0]           pos_sum;

   function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
      if (v > 19'sd32767) begin
         return 16'sh7fff;
      end else if (v < -19'sd32768) begin
         return 16'sh8000;
      end else begin
         return v[15:0];
      end
   endfunction

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         base_step_ff <= BASE_STEP_RESET;
         clip_ff      <= CLIP_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_BASE_STEP:   base_step_ff <= csr_wdata;
            CSR_CLIP_LENGTH: clip_ff <= csr_wdata[CLIP_W-1:0];
            default: ;
         endcase
      end
   end

   // end-of-clip check on the integer index
   assign idx      = pos_ff[POS_W-1:FRAC_BITS];
   assign idx_next = idx + 1'b1;
   assign frac     = pos_ff[FRAC_BITS-1:0];
   assign limit    = (CMP_W'(clip_ff) < CMP_W'(SAMPLE_DEPTH)) ? CMP_W'(clip_ff)
                                                              : CMP_W'(SAMPLE_DEPTH);
   assign status.at_end = (CMP_W'(idx) + 1'b1) >= limit;
   assign status.active = active_ff;

   // sample memory
   assign ram_we = ctl.take && (req_command == CMD_LOAD)
                   && (32'(req_load_address) < 32'(SAMPLE_DEPTH));
   assign ram_re    = ctl.rd_a || ctl.rd_b;
   assign ram_raddr = ctl.rd_b ? ADDR_W'(idx_next) : ADDR_W'(idx);

   ispm_ram #(
      .WIDTH(SAMPLE_W),
      .DEPTH(SAMPLE_DEPTH)
   ) u_sample_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ADDR_W'(req_load_address)),
      .wr_data(req_load_value),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   // phase step from base step and rate
   assign step_prod = base_step_ff * req_play_rate;

   // interpolation: a * 2^frac_bits + (b - a) * frac
   assign diff = $signed({ram_rdata[SAMPLE_W-1], ram_rdata}) - $signed({a_ff[SAMPLE_W-1], a_ff});
   assign term = diff * $signed({1'b0, frac});
   assign a_sh = NX_W'(a_ff) <<< FRAC_BITS;
   assign nx   = a_sh + term;
   assign n_in = nx[N_W-1:0];

   // gain scaling
   assign p_in = n_ff * $signed({1'b0, gain_ff});

   // truncate toward zero, add and saturate
   assign p_adj     = p_ff + (p_ff[P_W-1] ? ROUND_BIAS : '0);
   assign s_val     = $signed(p_adj[P_W-1:SHIFT]);
   assign sum_left  = 19'(left_ff) + 19'(s_val);
   assign sum_right = 19'(right_ff) + 19'(s_val);

   // position advance, saturating at the top
   assign inc_wide = (64'(step_ff) << FRAC_BITS) >> 16;
   assign pos_sum  = {1'b0, pos_ff} + inc_wide[CMP_W-1:0];

   always_comb begin
      pos_in       = pos_ff;
      active_in    = active_ff;
      res_left_in  = res_left_ff;
      res_right_in = res_right_ff;
      if (ctl.take && (req_command == CMD_PLAY)) begin
         pos_in    = '0;
         active_in = 1'b1;
      end else if (ctl.take && (req_command == CMD_STOP)) begin
         active_in = 1'b0;
      end
      if (ctl.pass) begin
         res_left_in  = left_ff;
         res_right_in = right_ff;
         if (status.at_end) begin
            active_in = 1'b0;
         end
      end
      if (ctl.mix) begin
         res_left_in  = sat16(sum_left);
         res_right_in = sat16(sum_right);
         pos_in = pos_sum[POS_W] ? {POS_W{1'b1}} : pos_sum[POS_W-1:0];
      end
   end

   // voice control state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         step_ff   <= '0;
         gain_ff   <= '0;
         active_ff <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         active_ff <= active_in;
         if (ctl.take && (req_command == CMD_PLAY)) begin
            step_ff <= step_prod[RATE_SHIFT +: STEP_W];
            gain_ff <= req_play_volume;
         end
      end
   end

   // payload pipeline registers
   always_ff @(posedge clock) begin
      if (ctl.take) begin
         left_ff  <= req_left_in;
         right_ff <= req_right_in;
      end
      if (ctl.rd_b) begin
         a_ff <= ram_rdata;
      end
      if (ctl.mul1) begin
         n_ff <= n_in;
      end
      if (ctl.mul2) begin
         p_ff <= p_in;
      end
      res_left_ff  <= res_left_in;
      res_right_ff <= res_right_in;
      if (ctl.pass) begin
         res_active_ff <= active_ff && !status.at_end;
      end else if (ctl.mix) begin
         res_active_ff <= 1'b1;
      end
      if (ctl.out_load) begin
         out_left_ff   <= res_left_ff;
         out_right_ff  <= res_right_ff;
         out_active_ff <= res_active_ff;
      end
   end

   assign rsp_left_out     = out_left_ff;
   assign rsp_right_out    = out_right_ff;
   assign rsp_voice_active = out_active_ff;

endmodule

// File: rtl/ispm_ctrl.sv
// controller: sequences one transaction at a time and owns the result valid
// depends on ispm_pkg
module ispm_ctrl import ispm_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic [1:0]    req_command,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type status,
   output ctl_cmd_type   ctl
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EVAL = 3'd1;
   localparam logic [2:0] ST_RD_B = 3'd2;
   localparam logic [2:0] ST_MUL1 = 3'd3;
   localparam logic [2:0] ST_MUL2 = 3'd4;
   localparam logic [2:0] ST_MIX  = 3'd5;
   localparam logic [2:0] ST_OUT  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       interp;

   assign req_stall = (state_ff != ST_IDLE);
   assign interp    = status.active && !status.at_end;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctl.take = 1'b1;
               if (req_command == CMD_MIX) begin
                  state_in = ST_EVAL;
               end
            end
         end
         ST_EVAL: begin
            if (interp) begin
               ctl.rd_a = 1'b1;
               state_in = ST_RD_B;
            end else begin
               ctl.pass = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_RD_B: begin
            ctl.rd_b = 1'b1;
            state_in = ST_MUL1;
         end
         ST_MUL1: begin
            ctl.mul1 = 1'b1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            ctl.mul2 = 1'b1;
            state_in = ST_MIX;
         end
         ST_MIX: begin
            ctl.mix  = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               ctl.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // checks
   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      ctl.out_load |=> rsp_valid_ff)
      else $error("result register load did not raise valid");

   a_out_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && rsp_valid_ff && rsp_stall) |=> (state_ff == ST_OUT))
      else $error("result overwritten while output stalled");

   a_frame_to_eval: assert property (@(posedge clock) disable iff (reset)
      (ctl.take && req_command == CMD_MIX) |=> (state_ff == ST_EVAL))
      else $error("accepted frame not evaluated");

   a_one_step: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl.take, ctl.pass, ctl.rd_a, ctl.rd_b, ctl.mul1, ctl.mul2, ctl.mix,
                ctl.out_load}))
      else $error("more than one datapath command at once");

   a_mix_after_read: assert property (@(posedge clock) disable iff (reset)
      ctl.mix |-> $past(ctl.mul2, 1) && $past(ctl.mul1, 2) && $past(ctl.rd_b, 3))
      else $error("mix step out of sequence");

endmodule

// File: bench/interpolating_sample_player_mixer_tb.sv
// self-checking testbench for the interpolating sample player mixer: directed and random
// command streams with random idle gaps and output stalls, checked by a built-in voice model
// depends on ispm_pkg and the interpolating_sample_player_mixer rtl
module interpolating_sample_player_mixer_tb import ispm_pkg::*;;

   localparam int RANDOM_ITEMS  = 450;
   localparam int PHASES        = 8;
   localparam int SETTLE_CYCLES = 12;
   localparam int LONG_HOLD     = 120;

   typedef struct {
      logic [1:0]                 command;
      logic signed [15:0]         left;
      logic signed [15:0]         right;
      logic [RATE_W-1:0]          rate;
      logic [GAIN_W-1:0]          volume;
      logic [LOAD_ADDR_W-1:0]     addr;
      logic signed [SAMPLE_W-1:0] value;
   } player_cmd_type;

   typedef struct {
      logic signed [15:0] left;
      logic signed [15:0] right;
      logic               voice;
   } mix_frame_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // request side
   logic           req_valid = 1'b0;
   logic           req_stall;
   player_cmd_type req_item = '{CMD_MIX, '0, '0, '0, '0, '0, '0};
   logic           req_taken = 1'b0;

   // result side
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_left_out;
   logic signed [15:0] rsp_right_out;
   logic               rsp_voice_active;

   // register write port
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_BASE_STEP;
   logic [BASE_STEP_W-1:0] csr_wdata = '0;

   // voice model, advanced on every accepted transaction
   logic signed [SAMPLE_W-1:0] sample_copy [SAMPLE_DEPTH];
   logic [POS_W-1:0]           voice_pos  = '0;
   logic [STEP_W-1:0]          voice_step = '0;
   logic [GAIN_W-1:0]          voice_gain = '0;
   logic                       voice_on   = 1'b0;
   logic [BASE_STEP_W-1:0]     cfg_base_step = BASE_STEP_RESET;
   logic [CLIP_W-1:0]          cfg_clip      = CLIP_RESET;

   // stimulus planning: tracks where the voice will read so no blank entry is touched
   bit               loaded_map [SAMPLE_DEPTH];
   logic [POS_W-1:0] plan_pos  = '0;
   logic [STEP_W-1:0] plan_step = '0;
   bit               plan_on   = 1'b0;
   int               queued_items = 0;

   player_cmd_type pending_cmds [$];
   mix_frame_type  expected_frames [$];
   int             mismatch_count = 0;

   // idling control
   bit steady = 1'b0;
   int gap_left = 0;
   int stall_left = 0;
   int stall_pick;
   int hold_left = 0;
   int hold_requests = 0;
   int holds_done = 0;

   interpolating_sample_player_mixer u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_item.command),
      .req_left_in      (req_item.left),
      .req_right_in     (req_item.right),
      .req_play_rate    (req_item.rate),
      .req_play_volume  (req_item.volume),
      .req_load_address (req_item.addr),
      .req_load_value   (req_item.value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_left_out     (rsp_left_out),
      .rsp_right_out    (rsp_right_out),
      .rsp_voice_active (rsp_voice_active),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // phase step latched by a play: base_step times rate, Q4.12 rate dropped
   function automatic logic [STEP_W-1:0] step_for(logic [BASE_STEP_W-1:0] base,
                                                 logic [RATE_W-1:0] rate);
      logic [BASE_STEP_W+RATE_W-1:0] prod;
      prod = base * rate;
      return prod[RATE_SHIFT +: STEP_W];
   endfunction

   // position after one frame, step rescaled to the position's fraction, saturating
   function automatic logic [POS_W-1:0] next_position(logic [POS_W-1:0] pos,
                                                     logic [STEP_W-1:0] step);
      logic [63:0] inc;
      logic [63:0] sum;
      inc = 64'(step);
      if (FRAC_BITS > 16) inc = inc << (FRAC_BITS - 16);
      else inc = inc >> (16 - FRAC_BITS);
      sum = 64'(pos) + inc;
      return (sum > 64'hFFFF_FFFF) ? '1 : sum[POS_W-1:0];
   endfunction

   function automatic int play_limit(logic [CLIP_W-1:0] clip);
      return (clip < SAMPLE_DEPTH) ? int'(clip) : SAMPLE_DEPTH;
   endfunction

   function automatic logic signed [15:0] sat16(longint v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   // apply one accepted transaction to the voice model, queue the frame it yields
   task automatic predict_player(player_cmd_type c);
      longint l, r, a, b, n, s, frac;
      int     idx;
      case (c.command)
         CMD_PLAY: begin
            voice_step = step_for(cfg_base_step, c.rate);
            voice_gain = c.volume;
            voice_pos  = '0;
            voice_on   = 1'b1;
         end
         CMD_STOP: voice_on = 1'b0;
         CMD_LOAD: sample_copy[c.addr] = c.value;
         default: begin
            l = c.left;
            r = c.right;
            if (voice_on) begin
               idx = voice_pos >> FRAC_BITS;
               // last index of the clip ends the voice, frame passes untouched
               if (idx + 1 >= play_limit(cfg_clip)) begin
                  voice_on = 1'b0;
               end else begin
                  frac = voice_pos[FRAC_BITS-1:0];
                  a = sample_copy[idx];
                  b = sample_copy[idx + 1];
                  n = a * (longint'(1) << FRAC_BITS) + (b - a) * frac;
                  // signed division truncates toward zero
                  s = (n * longint'(voice_gain)) / (longint'(1) << (FRAC_BITS + 15));
                  l = l + s;
                  r = r + s;
                  voice_pos = next_position(voice_pos, voice_step);
               end
            end
            expected_frames.push_back('{sat16(l), sat16(r), voice_on});
         end
      endcase
   endtask

   task automatic report_mismatch(string what);
      mismatch_count++;
      $display("mismatch at %0t: %s", $time, what);
   endtask

   // command with every field random, then shaped by operation
   function automatic player_cmd_type random_cmd(logic [1:0] op);
      player_cmd_type c;
      int             pick;
      c.command = op;
      c.left    = 16'($urandom);
      c.right   = 16'($urandom);
      c.rate    = RATE_W'($urandom);
      c.volume  = GAIN_W'($urandom);
      c.addr    = LOAD_ADDR_W'($urandom);
      c.value   = SAMPLE_W'($urandom);
      pick = $urandom_range(0, 99);
      case (op)
         CMD_MIX: begin
            if (pick < 15) begin
               c.left  = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
               c.right = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            end
         end
         CMD_PLAY: begin
            if (pick < 40) c.rate = RATE_W'($urandom_range(0, 8192));
            else if (pick < 55) c.rate = RATE_W'(4096);
            else if (pick < 75) c.rate = RATE_W'($urandom_range(256, 20000));
            pick = $urandom_range(0, 99);
            if (pick < 10) c.volume = GAIN_W'(32768);
            else if (pick < 15) c.volume = '0;
            else if (pick < 22) c.volume = GAIN_W'($urandom_range(32769, 65535));
            else c.volume = GAIN_W'($urandom_range(0, 32768));
         end
         CMD_LOAD: begin
            if (pick < 75) c.addr = LOAD_ADDR_W'($urandom_range(0, 127));
            if ($urandom_range(0, 9) == 0)
               c.value = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
         end
         default: ;
      endcase
      return c;
   endfunction

   // queue a transaction; loads any sample the voice is about to read for the first time
   task automatic push_item(player_cmd_type c);
      player_cmd_type fill;
      int             idx;
      case (c.command)
         CMD_PLAY: begin
            plan_step = step_for(cfg_base_step, c.rate);
            plan_pos  = '0;
            plan_on   = 1'b1;
         end
         CMD_STOP: plan_on = 1'b0;
         CMD_LOAD: loaded_map[c.addr] = 1'b1;
         default: begin
            if (plan_on) begin
               idx = plan_pos >> FRAC_BITS;
               if (idx + 1 >= play_limit(cfg_clip)) begin
                  plan_on = 1'b0;
               end else begin
                  for (int k = idx; k <= idx + 1; k++) begin
                     if (!loaded_map[k]) begin
                        fill = random_cmd(CMD_LOAD);
                        fill.addr = LOAD_ADDR_W'(k);
                        loaded_map[k] = 1'b1;
                        pending_cmds.push_back(fill);
                        queued_items++;
                     end
                  end
                  plan_pos = next_position(plan_pos, plan_step);
               end
            end
         end
      endcase
      pending_cmds.push_back(c);
      queued_items++;
   endtask

   // directed transaction: x, y are left/right, rate/volume or address/value
   task automatic push_directed(logic [1:0] op, int x, int y);
      player_cmd_type c;
      c = random_cmd(op);
      case (op)
         CMD_MIX: begin
            c.left  = 16'(x);
            c.right = 16'(y);
         end
         CMD_PLAY: begin
            c.rate   = RATE_W'(x);
            c.volume = GAIN_W'(y);
         end
         CMD_LOAD: begin
            c.addr  = LOAD_ADDR_W'(x);
            c.value = SAMPLE_W'(y);
         end
         default: ;
      endcase
      push_item(c);
   endtask

   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // wait until every queued transaction is taken and every frame has come back
   task automatic wait_drained();
      do @(posedge clock);
      while (pending_cmds.size() != 0 || req_valid || expected_frames.size() != 0);
   endtask

   task automatic set_registers(logic [BASE_STEP_W-1:0] base, logic [CLIP_W-1:0] clip);
      logic [1:0] upper;
      upper = 2'($urandom_range(0, 3));
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= CSR_BASE_STEP;
      csr_wdata <= base;
      do @(posedge clock);
      while (!csr_ready);
      @(negedge clock);
      csr_index <= CSR_CLIP_LENGTH;
      csr_wdata <= {upper, clip};
      do @(posedge clock);
      while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // request driver: next transaction only after the current one is taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_cmds.size() > 0) begin
            req_item  <= pending_cmds.pop_front();
            req_valid <= 1'b1;
            gap_left = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result stall: random short and long stretches, plus requested long holds
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (holds_done < hold_requests) begin
         holds_done++;
         hold_left = LONG_HOLD;
         rsp_stall <= 1'b1;
      end else if (steady) begin
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         stall_pick = $urandom_range(0, 99);
         if (stall_pick < 70) begin
            rsp_stall <= 1'b0;
         end else if (stall_pick < 96) begin
            stall_left = $urandom_range(0, 2);
            rsp_stall <= 1'b1;
         end else begin
            stall_left = $urandom_range(8, 30);
            rsp_stall <= 1'b1;
         end
      end
   end

   // monitor: register writes, accepted transactions and returned frames
   always @(posedge clock) begin
      mix_frame_type want;
      req_taken <= req_valid && !req_stall && !reset;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_BASE_STEP) cfg_base_step = csr_wdata;
            else cfg_clip = csr_wdata[CLIP_W-1:0];
         end
         if (req_valid && !req_stall) predict_player(req_item);
         if (rsp_valid && !rsp_stall) begin
            if (expected_frames.size() == 0) begin
               report_mismatch($sformatf("unexpected frame left %0d right %0d active %0b",
                                         rsp_left_out, rsp_right_out, rsp_voice_active));
            end else begin
               want = expected_frames.pop_front();
               if (rsp_left_out !== want.left || rsp_right_out !== want.right ||
                   rsp_voice_active !== want.voice)
                  report_mismatch($sformatf(
                     "frame left %0d/%0d right %0d/%0d active %0b/%0b (got/want)",
                     rsp_left_out, want.left, rsp_right_out, want.right,
                     rsp_voice_active, want.voice));
            end
         end
      end
   end

   // stimulus: directed opening, then register settings with random traffic
   initial begin
      int          phase_base [PHASES];
      int          phase_clip [PHASES];
      int          start_count;
      int          pick;
      logic [1:0]  op;
      logic [BASE_STEP_W-1:0] base;
      logic [CLIP_W-1:0]      clip;

      phase_base = '{65536, 262143, 0, 65536, 32768, -1, 131072, -1};
      phase_clip = '{32768, 65535, 2, 0, 1, -1, 40, 32768};

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: passthrough, extremes, interpolation, zero step, restart, stop
      push_directed(CMD_MIX, 32767, -32768);
      push_directed(CMD_STOP, 0, 0);
      push_directed(CMD_LOAD, 0, 32767);
      push_directed(CMD_LOAD, 1, -32768);
      push_directed(CMD_LOAD, 2, 0);
      push_directed(CMD_LOAD, 32767, -1);
      push_directed(CMD_LOAD, 3, 12345);
      push_directed(CMD_PLAY, 4096, 32768);
      push_directed(CMD_MIX, 32767, -32768);
      push_directed(CMD_MIX, 0, 0);
      push_directed(CMD_MIX, -32768, -32768);
      push_directed(CMD_PLAY, 2048, 65535);
      push_directed(CMD_MIX, 100, -100);
      push_directed(CMD_MIX, 0, 0);
      push_directed(CMD_MIX, -1, 1);
      push_directed(CMD_PLAY, 0, 16384);
      push_directed(CMD_MIX, 5, 5);
      push_directed(CMD_MIX, -5, -5);
      push_directed(CMD_PLAY, 65535, 0);
      push_directed(CMD_MIX, 1, 2);
      push_directed(CMD_MIX, 3, 4);
      push_directed(CMD_STOP, 0, 0);
      push_directed(CMD_MIX, -32768, 32767);

      for (int p = 0; p < PHASES; p++) begin
         if (p > 0) begin
            wait_drained();
            repeat (SETTLE_CYCLES) @(posedge clock);
            base = (phase_base[p] < 0) ? BASE_STEP_W'($urandom_range(0, 262143))
                                       : BASE_STEP_W'(phase_base[p]);
            clip = (phase_clip[p] < 0) ? CLIP_W'($urandom_range(2, 200))
                                       : CLIP_W'(phase_clip[p]);
            set_registers(base, clip);
         end
         steady = (p % 3 == 2);

         // random traffic, mostly play followed by bursts of frames
         start_count = queued_items;
         while (queued_items - start_count < RANDOM_ITEMS / PHASES) begin
            pick = $urandom_range(0, 99);
            if (!plan_on && pick < 35) op = CMD_PLAY;
            else if (pick < 60) op = CMD_MIX;
            else if (pick < 78) op = CMD_LOAD;
            else if (pick < 92) op = CMD_PLAY;
            else op = CMD_STOP;
            if (op == CMD_MIX) begin
               repeat ($urandom_range(1, 8)) push_item(random_cmd(CMD_MIX));
            end else begin
               push_item(random_cmd(op));
            end
         end

         // long receiver hold while the queue is full so the block backs up
         if (p == 1 || p == 5) hold_requests++;
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #10_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
